// ----- rtl/core/brfd_pkg.sv -----
// ----------------------------------------------------------------------------
// brfd_pkg
// Shared types and constants for the byte-run frame decoder.
// ----------------------------------------------------------------------------
package brfd_pkg;

    localparam int unsigned FRAME_PIXELS = 64000;
    localparam logic [16:0] FRAME_PIXELS_W = 17'(FRAME_PIXELS);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] code_byte;
        logic       chunk_start;
    } t_in_req;

    typedef struct packed {
        logic [15:0] write_addr;
        logic [7:0]  pixel_value;
        logic [6:0]  run_len;
        logic        frame_done;
    } t_out_req;

    typedef enum logic [2:0] {
        PH_PACKETS,
        PH_COUNT,
        PH_LITERAL,
        PH_REPEAT,
        PH_DONE
    } t_phase;

    // restart: first command after a chunk start, back end restarts at zero
    // frame_end: end code, no pixels written
    typedef struct packed {
        logic       restart;
        logic       frame_end;
        logic [7:0] value;
        logic [6:0] len;
    } t_cmd;

endpackage

// ----- rtl/core/brfd_front.sv -----
// ----------------------------------------------------------------------------
// brfd_front
// Parses code bytes into packets and pushes write commands to the queue.
// ----------------------------------------------------------------------------
module brfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  brfd_pkg::t_in_req i_in_req,
    input  logic             i_q_full,
    output logic             o_push,
    output brfd_pkg::t_cmd   o_cmd
);
    import brfd_pkg::*;

    t_phase     r_phase, n_phase, cur_phase;
    logic [7:0] r_packets_left, n_packets_left, cur_packets;
    logic [6:0] r_literal_left, n_literal_left;
    logic [6:0] r_repeat_len, n_repeat_len;
    logic       r_restart_pend, n_restart_pend;
    logic       accept;
    logic [7:0] b;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_req.code_byte;
    assign cur_phase  = i_in_req.chunk_start ? PH_PACKETS : r_phase;
    assign cur_packets = i_in_req.chunk_start ? 8'd0 : r_packets_left;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (cur_phase)
                PH_PACKETS: n_phase = (b != 8'd0) ? PH_COUNT : PH_PACKETS;
                PH_COUNT: begin
                    if (b == 8'd0) begin
                        n_phase = PH_DONE;
                    end else if (b[7]) begin
                        n_phase = PH_LITERAL;
                    end else begin
                        n_phase = PH_REPEAT;
                    end
                end
                PH_LITERAL: begin
                    if (r_literal_left == 7'd0) begin
                        n_phase = (cur_packets != 8'd0) ? PH_COUNT : PH_PACKETS;
                    end
                end
                PH_REPEAT: n_phase = (cur_packets != 8'd0) ? PH_COUNT : PH_PACKETS;
                PH_DONE:   n_phase = PH_DONE;
                default:   n_phase = PH_DONE;
            endcase
        end
    end

    // outputs and counters
    always_comb begin
        n_packets_left = r_packets_left;
        n_literal_left = r_literal_left;
        n_repeat_len   = r_repeat_len;
        o_push         = 1'b0;
        o_cmd          = '0;
        if (accept) begin
            unique case (cur_phase)
                PH_PACKETS: n_packets_left = b;
                PH_COUNT: begin
                    n_packets_left = cur_packets - 8'd1;
                    if (b == 8'd0) begin
                        o_push          = 1'b1;
                        o_cmd.frame_end = 1'b1;
                    end else if (b[7]) begin
                        n_literal_left = ~b[6:0];
                    end else begin
                        n_repeat_len = b[6:0];
                    end
                end
                PH_LITERAL: begin
                    o_push      = 1'b1;
                    o_cmd.value = b;
                    o_cmd.len   = 7'd1;
                    if (r_literal_left != 7'd0) begin
                        n_literal_left = r_literal_left - 7'd1;
                    end
                end
                PH_REPEAT: begin
                    o_push      = 1'b1;
                    o_cmd.value = b;
                    o_cmd.len   = r_repeat_len;
                end
                PH_DONE: ;
                default: ;
            endcase
        end
        o_cmd.restart  = r_restart_pend;
        n_restart_pend = (r_restart_pend || (accept && i_in_req.chunk_start)) && !o_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PACKETS;
            r_packets_left <= '0;
            r_literal_left <= '0;
            r_repeat_len   <= '0;
            r_restart_pend <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_packets_left <= n_packets_left;
            r_literal_left <= n_literal_left;
            r_repeat_len   <= n_repeat_len;
            r_restart_pend <= n_restart_pend;
        end
    end

    property p_no_push_from_header;
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && cur_phase == PH_PACKETS) |-> !o_push;
    endproperty
    a_no_push_from_header: assert property (p_no_push_from_header)
        else $error("push on packet count byte");

    property p_restart_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_req.chunk_start) |=> (r_restart_pend && r_phase != PH_DONE);
    endproperty
    a_restart_clears: assert property (p_restart_clears)
        else $error("chunk start not recorded");

    property p_end_code;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.frame_end) |=> (r_phase == PH_DONE);
    endproperty
    a_end_code: assert property (p_end_code)
        else $error("end code did not finish frame");

endmodule

// ----- rtl/core/brfd_queue.sv -----
// ----------------------------------------------------------------------------
// brfd_queue
// Short command queue between the parser and the write generator.
// ----------------------------------------------------------------------------
module brfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brfd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output brfd_pkg::t_cmd o_cmd
);
    import brfd_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            r_count <= r_count + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full);
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue overflow");

    property p_no_underflow;
        @(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty);
    endproperty
    a_no_underflow: assert property (p_no_underflow)
        else $error("queue underflow");

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH);
    endproperty
    a_count_range: assert property (p_count_range)
        else $error("queue count out of range");

endmodule

// ----- rtl/core/brfd_back.sv -----
// ----------------------------------------------------------------------------
// brfd_back
// Tracks the frame address, clips runs at the frame end, registers writes.
// ----------------------------------------------------------------------------
module brfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  brfd_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output brfd_pkg::t_out_req o_out_req
);
    import brfd_pkg::*;

    logic [15:0] r_addr, n_addr, eff_addr;
    logic        r_done, n_done, eff_done;
    logic        r_out_valid;
    t_out_req    r_out;
    logic        slot_free, drop;
    logic [16:0] room, sum;
    logic [6:0]  n_len;
    logic        hit_end;

    assign slot_free = !r_out_valid || i_out_ready;
    assign o_pop     = !i_q_empty && slot_free;
    assign eff_addr  = i_cmd.restart ? 16'd0 : r_addr;
    assign eff_done  = i_cmd.restart ? 1'b0 : r_done;
    assign drop      = eff_done;

    always_comb begin
        room    = ({1'b0, eff_addr} < FRAME_PIXELS_W) ? (FRAME_PIXELS_W - {1'b0, eff_addr})
                                                      : 17'd0;
        n_len   = (room < {10'd0, i_cmd.len}) ? room[6:0] : i_cmd.len;
        sum     = {1'b0, eff_addr} + {10'd0, n_len};
        hit_end = i_cmd.frame_end || (sum >= FRAME_PIXELS_W);
        n_addr  = r_addr;
        n_done  = r_done;
        if (o_pop) begin
            n_addr = eff_addr;
            n_done = eff_done;
            if (!drop) begin
                n_addr = sum[15:0];
                n_done = hit_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_done <= n_done;
            if (o_pop && !drop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !drop) begin
            r_out.write_addr  <= eff_addr;
            r_out.pixel_value <= i_cmd.value;
            r_out.run_len     <= n_len;
            r_out.frame_done  <= hit_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    property p_addr_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_addr} <= FRAME_PIXELS_W;
    endproperty
    a_addr_bound: assert property (p_addr_bound)
        else $error("address past frame end");

    property p_empty_write_ends;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.run_len == 7'd0) |-> r_out.frame_done;
    endproperty
    a_empty_write_ends: assert property (p_empty_write_ends)
        else $error("zero length write without frame end");

    property p_done_sticky;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !(o_pop && i_cmd.restart)) |=> r_done;
    endproperty
    a_done_sticky: assert property (p_done_sticky)
        else $error("frame end cleared without restart");

endmodule

// ----- rtl/core/byte_run_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// byte_run_frame_decoder
// Byte-run frame decoder: code bytes in, pixel write requests out.
//
//   channel  direction  handshake             payload
//   in       input      i_in_valid/o_in_ready  i_in_req  (t_in_req)
//   out      output     o_out_valid/i_out_ready o_out_req (t_out_req)
//
// One code byte per cycle sustained while the queue has room; a write request
// passes from the parser through the four-entry queue into the output register.
// Synchronous active-low reset returns to "expect packet count", address 0.
// Input stalls only when the queue is full; the output register holds a
// request until taken while parsing continues into the queue.
// ----------------------------------------------------------------------------
module byte_run_frame_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  brfd_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output brfd_pkg::t_out_req o_out_req
);
    import brfd_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd push_cmd, head_cmd;

    brfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    brfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    brfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

endmodule

// ----- test/byte_run_frame_decoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_frame_decoder_checker
// Watches both channels of the byte-run frame decoder. It decodes every
// accepted code byte with its own copy of the frame state, queues the
// write requests that byte should produce, and compares each accepted
// output request field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module byte_run_frame_decoder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  brfd_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  brfd_pkg::t_out_req i_out_req,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_writes_seen,
    output int                 o_end_codes,
    output int                 o_full_frames
);

    import brfd_pkg::*;

    t_phase      dec_phase;
    logic [7:0]  dec_packets;
    logic [6:0]  dec_literals;
    logic [6:0]  dec_repeat;
    logic [15:0] dec_addr;
    t_out_req    expected_writes[$];
    int          reported;

    function automatic void clear_decoder();
        dec_phase    = PH_PACKETS;
        dec_packets  = 8'd0;
        dec_literals = 7'd0;
        dec_repeat   = 7'd0;
        dec_addr     = 16'd0;
    endfunction

    function automatic void push_write(logic [15:0] addr, logic [7:0] value,
                                       logic [6:0] len, logic done);
        t_out_req w;
        w.write_addr  = addr;
        w.pixel_value = value;
        w.run_len     = len;
        w.frame_done  = done;
        expected_writes.push_back(w);
    endfunction

    function automatic void end_packet();
        dec_phase = (dec_packets != 8'd0) ? PH_COUNT : PH_PACKETS;
    endfunction

    function automatic void decode_byte(t_in_req r);
        int unsigned addr;
        int unsigned room;
        int unsigned len;
        logic        done;
        if (r.chunk_start) clear_decoder();
        addr = dec_addr;
        case (dec_phase)
            PH_PACKETS: begin
                dec_packets = r.code_byte;
                if (r.code_byte != 8'd0) dec_phase = PH_COUNT;
            end
            PH_COUNT: begin
                dec_packets = dec_packets - 8'd1;
                if (r.code_byte == 8'd0) begin
                    dec_phase = PH_DONE;
                    push_write(dec_addr, 8'd0, 7'd0, 1'b1);
                end else if (r.code_byte > 8'd127) begin
                    dec_literals = 7'(8'd255 - r.code_byte);
                    dec_phase    = PH_LITERAL;
                end else begin
                    dec_repeat = r.code_byte[6:0];
                    dec_phase  = PH_REPEAT;
                end
            end
            PH_LITERAL: begin
                if (addr >= FRAME_PIXELS) begin
                    dec_phase = PH_DONE;
                    push_write(dec_addr, r.code_byte, 7'd0, 1'b1);
                end else begin
                    done     = (addr + 1 >= FRAME_PIXELS);
                    dec_addr = 16'(addr + 1);
                    if (done) dec_phase = PH_DONE;
                    else if (dec_literals == 7'd0) end_packet();
                    else dec_literals = dec_literals - 7'd1;
                    push_write(16'(addr), r.code_byte, 7'd1, done);
                end
            end
            PH_REPEAT: begin
                room = (addr < FRAME_PIXELS) ? FRAME_PIXELS - addr : 0;
                len  = dec_repeat;
                if (len > room) len = room;
                done     = (addr + len >= FRAME_PIXELS);
                dec_addr = 16'(addr + len);
                if (done) dec_phase = PH_DONE;
                else end_packet();
                push_write(16'(addr), r.code_byte, 7'(len), done);
            end
            default: dec_phase = PH_DONE;
        endcase
    endfunction

    function automatic void check_write(t_out_req got);
        t_out_req want;
        o_writes_seen++;
        if (expected_writes.size() == 0) begin
            o_fail_count++;
            if (reported < 10)
                $display("Unexpected write request: addr %0d value %02h len %0d done %0b",
                         got.write_addr, got.pixel_value, got.run_len, got.frame_done);
            reported++;
            return;
        end
        want = expected_writes.pop_front();
        if (want.frame_done && want.run_len == 7'd0) o_end_codes++;
        else if (want.frame_done) o_full_frames++;
        if (got.write_addr !== want.write_addr || got.pixel_value !== want.pixel_value ||
            got.run_len !== want.run_len || got.frame_done !== want.frame_done) begin
            o_fail_count++;
            if (reported < 10) begin
                $display("Write mismatch: expected addr %0d value %02h len %0d done %0b",
                         want.write_addr, want.pixel_value, want.run_len, want.frame_done);
                $display("                got      addr %0d value %02h len %0d done %0b",
                         got.write_addr, got.pixel_value, got.run_len, got.frame_done);
            end
            reported++;
        end
    endfunction

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_writes_seen = 0;
        o_end_codes   = 0;
        o_full_frames = 0;
        reported      = 0;
        clear_decoder();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            expected_writes.delete();
        end else begin
            if (i_in_valid && i_in_ready) decode_byte(i_in_req);
            if (i_out_valid && i_out_ready) check_write(i_out_req);
        end
        o_pending = expected_writes.size();
    end

endmodule

// ----- test/byte_run_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_run_frame_decoder_tb
// Drives code-byte streams into the decoder: a directed opening, short
// random frames with noise and cut-off packets, and one frame filled to
// the pixel total (ending on a clipped repeat or inside a literal).
// Both channels idle at random; a long output hold-off backs up the block.
// ----------------------------------------------------------------------------
module byte_run_frame_decoder_tb;

    import brfd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_req    = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_req out_req;

    int fail_count;
    int pending;
    int writes_seen;
    int end_codes;
    int full_frames;

    int bytes_sent    = 0;
    int input_stalls  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int cycles        = 0;
    bit no_gaps       = 1'b0;
    bit next_start    = 1'b0;
    int line_packets  = 0;

    byte_run_frame_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    byte_run_frame_decoder_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_req      (in_req),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_req     (out_req),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_writes_seen (writes_seen),
        .o_end_codes   (end_codes),
        .o_full_frames (full_frames)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (in_valid && !in_ready) input_stalls++;
            if (cycles == CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles with %0d writes outstanding", cycles, pending);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int      gap;
        t_in_req r;
        gap           = pick_gap();
        r.code_byte   = value;
        r.chunk_start = next_start;
        next_start    = 1'b0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic start_frame();
        next_start   = 1'b1;
        line_packets = 0;
        no_gaps      = ($urandom_range(0, 4) == 0);
    endtask

    // new line header when the current line has no packets left
    task automatic open_packet(input int max_count);
        if (line_packets == 0) begin
            if ($urandom_range(0, 9) == 0) send_byte(8'd0);
            line_packets = $urandom_range(1, max_count);
            send_byte(8'(line_packets));
        end
        line_packets--;
    endtask

    task automatic repeat_packet(input int max_count, input int len);
        open_packet(max_count);
        send_byte(8'(len));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic literal_packet(input int max_count, input int len);
        open_packet(max_count);
        send_byte(8'(256 - len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 8)) begin
            next_start = ($urandom_range(0, 7) == 0);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic short_frame();
        int ending;
        start_frame();
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) < 4)
                literal_packet(6, ($urandom_range(0, 24) == 0) ? 128 : $urandom_range(1, 6));
            else
                repeat_packet(6, $urandom_range(1, 127));
        end
        ending = $urandom_range(0, 9);
        if (ending < 7) begin
            open_packet(6);
            send_byte(8'd0);
            // bytes after the end code are dropped
            if (ending < 2) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end else if (ending < 9) begin
            open_packet(6);
            send_byte(8'($urandom_range(1, 255)));
        end else begin
            noise_burst();
        end
    endtask

    task automatic random_frames(input int until_bytes);
        while (bytes_sent < until_bytes) begin
            if ($urandom_range(0, 9) == 0) noise_burst();
            else short_frame();
        end
    endtask

    // fills all FRAME_PIXELS; ends on a clipped repeat or mid-literal
    task automatic fill_frame(input bit end_on_literal);
        int left;
        int len;
        start_frame();
        left = FRAME_PIXELS;
        while (left > 227) begin
            if ($urandom_range(0, 31) == 0) begin
                len = $urandom_range(1, 3);
                literal_packet(255, len);
            end else begin
                len = $urandom_range(122, 127);
                repeat_packet(255, len);
            end
            left -= len;
        end
        repeat_packet(255, left - 100);
        if (end_on_literal) begin
            repeat_packet(255, 90);
            literal_packet(255, $urandom_range(10, 24));
        end else begin
            repeat_packet(255, $urandom_range(101, 127));
        end
        repeat (3) send_byte(8'($urandom_range(0, 255)));
    endtask

    // output side: random stalls, plus the long hold-off on request
    initial begin
        int len;
        int i;
        bit level;
        level = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                level = ~level;
                if (level)
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 8);
                else if ($urandom_range(0, 99) < 70)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 99) < 85)
                    len = $urandom_range(3, 10);
                else
                    len = $urandom_range(11, 40);
                out_ready <= level;
                i = 0;
                do begin
                    @(posedge clk);
                    i++;
                end while (i < len && hold_requests == holds_served);
            end
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening
        next_start = 1'b1;
        send_byte(8'd3);
        send_byte(8'd127);
        send_byte(8'hFF);
        send_byte(8'd255);
        send_byte(8'h00);
        send_byte(8'd254);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'd0);
        send_byte(8'd255);
        send_byte(8'd1);
        send_byte(8'h80);
        send_byte(8'd0);
        send_byte(8'hAA);
        next_start = 1'b1;
        send_byte(8'd1);
        send_byte(8'd5);
        send_byte(8'h01);
        send_byte(8'd128);
        send_byte(8'h7F);
        send_byte(8'hFE);
        next_start = 1'b1;
        send_byte(8'd2);
        send_byte(8'd127);
        send_byte(8'h55);
        send_byte(8'd0);
        drain();

        random_frames(bytes_sent + 100);

        // back up the block: output held while repeats stream in
        hold_requests++;
        start_frame();
        no_gaps = 1'b1;
        repeat (30) repeat_packet(255, $urandom_range(1, 127));

        random_frames(bytes_sent + 100);
        drain();
        fill_frame(1'($urandom_range(0, 1)));
        random_frames(bytes_sent + 80);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d code bytes, %0d input stall cycles; short frames, noise, one full frame",
                 bytes_sent, input_stalls);
        $display("Checked %0d write requests, %0d end codes, %0d frames filled to the pixel total",
                 writes_seen, end_codes, full_frames);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
